// File: design/iffm_pkg.sv
// Shared types and constants for the IFF mesh chunk parser.
package iffm_pkg;

  localparam logic [31:0] ID_FORM = 32'h464F_524D;
  localparam logic [31:0] ID_PNTS = 32'h504E_5453;
  localparam logic [31:0] ID_POLS = 32'h504F_4C53;

  localparam logic [3:0] VERTEX_BYTES = 4'd12;
  localparam logic [3:0] FACE_BYTES   = 4'd10;
  localparam logic [1:0] HDR_LAST     = 2'd3;
  localparam logic [15:0] FACE_VERTS  = 16'd3;
  localparam logic [23:0] COUNT_MAX   = 24'hFF_FFFF;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_FACE   = 1'b1;

  typedef enum logic [1:0] {
    PH_ID,
    PH_SIZE,
    PH_FORM_TYPE,
    PH_BODY
  } iffm_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } iffm_beat_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] value_a;
    logic [31:0] value_b;
    logic [31:0] value_c;
    logic [23:0] number;
    logic        count_error;
  } iffm_result_t;

endpackage

// File: design/iff_mesh_chunk_parser.sv
// Top level of the streaming IFF mesh chunk parser.
//
//   channel | direction | handshake                    | payload
//   --------+-----------+------------------------------+-----------------------------------
//   in      | input     | in_valid_i / in_stall_o      | data_byte_i, file_start_i
//   out     | output    | out_valid_o / out_stall_i    | item_kind_o, value_a_o, value_b_o,
//           |           |                              | value_c_o, item_number_o,
//           |           |                              | count_error_o
//
// One byte beat is taken every cycle while the input is not stalled; the chunk state is updated in a single pass.
// A result becomes valid on the outputs after the byte that completes its record
// is accepted: that byte is first registered in the input register, and the result
// is then registered in the result register.
// While the result register is full and stalled the parser does not advance, so a byte
// waiting in the input register holds and the input stalls at once, or after one more
// beat when the input register was empty.
// Reset clears the parse state but not the record words; file_start_i restarts the parse on its own byte.
module iff_mesh_chunk_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        file_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        item_kind_o,
  output logic [31:0] value_a_o,
  output logic [31:0] value_b_o,
  output logic [31:0] value_c_o,
  output logic [23:0] item_number_o,
  output logic        count_error_o
);
  import iffm_pkg::*;

  iffm_beat_t   beat_in;
  iffm_beat_t   beat_held;
  logic         beat_valid;
  logic         out_ready;
  logic         fire;
  logic         emit;
  iffm_result_t result_new;
  iffm_result_t result_out;

  assign beat_in.data  = data_byte_i;
  assign beat_in.start = file_start_i;
  assign fire          = beat_valid && out_ready;

  iffm_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .beat_i     (beat_in),
    .take_i     (fire),
    .valid_o    (beat_valid),
    .beat_o     (beat_held)
  );

  iffm_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .beat_i   (beat_held),
    .emit_o   (emit),
    .result_o (result_new)
  );

  iffm_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .result_i    (result_new),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_out)
  );

  assign item_kind_o   = result_out.kind;
  assign value_a_o     = result_out.value_a;
  assign value_b_o     = result_out.value_b;
  assign value_c_o     = result_out.value_c;
  assign item_number_o = result_out.number;
  assign count_error_o = result_out.count_error;

endmodule

// File: design/iffm_in_reg.sv
// Input register that holds one incoming byte beat until the parser consumes it.
module iffm_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  iffm_pkg::iffm_beat_t beat_i,
  input  logic               take_i,
  output logic               valid_o,
  output iffm_pkg::iffm_beat_t beat_o
);
  import iffm_pkg::*;

  logic       valid_q;
  iffm_beat_t beat_q;
  logic       load;

  // A held beat blocks new input unless it leaves in this cycle.
  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// File: design/iffm_parse.sv
// Chunk header, FORM nesting and record assembly state with its update logic.
module iffm_parse (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  iffm_pkg::iffm_beat_t   beat_i,
  output logic                   emit_o,
  output iffm_pkg::iffm_result_t result_o
);
  import iffm_pkg::*;

  iffm_phase_e phase_q, phase_d, c_phase;
  logic [1:0]  hdr_q, hdr_d, c_hdr;
  logic [31:0] id_q, id_d, c_id;
  logic [31:0] chunk_q, chunk_d, c_chunk;
  logic [31:0] form_q, form_d, c_form;
  logic        inside_q, inside_d, c_inside;
  logic [3:0]  rec_q, rec_d, c_rec;
  logic [23:0] vcnt_q, vcnt_d, c_vcnt;
  logic [23:0] fcnt_q, fcnt_d, c_fcnt;
  logic [31:0] words_q [3];
  logic [31:0] words_d [3];

  logic [31:0] form_dec;
  logic        form_end;
  logic [31:0] chunk_dec;
  logic [31:0] size_new;
  logic [31:0] size_clamp;
  logic        is_data;
  logic [3:0]  rec_inc;
  logic        pnts_done;
  logic        pols_done;
  logic        body_data;

  // A start flag makes this byte see the reset state.
  always_comb begin
    c_phase  = beat_i.start ? PH_ID : phase_q;
    c_hdr    = beat_i.start ? 2'd0 : hdr_q;
    c_id     = beat_i.start ? 32'd0 : id_q;
    c_chunk  = beat_i.start ? 32'd0 : chunk_q;
    c_form   = beat_i.start ? 32'd0 : form_q;
    c_inside = beat_i.start ? 1'b0 : inside_q;
    c_rec    = beat_i.start ? 4'd0 : rec_q;
    c_vcnt   = beat_i.start ? 24'd0 : vcnt_q;
    c_fcnt   = beat_i.start ? 24'd0 : fcnt_q;

    form_dec   = (c_inside && (c_form != 32'd0)) ? c_form - 32'd1 : c_form;
    form_end   = c_inside && (form_dec == 32'd0);
    chunk_dec  = (c_chunk != 32'd0) ? c_chunk - 32'd1 : c_chunk;
    size_new   = {c_chunk[23:0], beat_i.data};
    size_clamp = (c_inside && (size_new > form_dec)) ? form_dec : size_new;
    is_data    = c_inside && ((c_id == ID_PNTS) || (c_id == ID_POLS));
    body_data  = (c_phase == PH_BODY) && is_data;
    rec_inc    = c_rec + 4'd1;
    pnts_done  = (c_id == ID_PNTS) && (rec_inc >= VERTEX_BYTES);
    pols_done  = (c_id == ID_POLS) && (rec_inc >= FACE_BYTES);
  end

  // Record words: the first byte of a word replaces it, later bytes shift in.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      words_d[i] = words_q[i];
      if (body_data && (c_rec[3:2] == 2'(i))) begin
        words_d[i] = (c_rec[1:0] == 2'd0) ? {24'd0, beat_i.data}
                                          : {words_q[i][23:0], beat_i.data};
      end
    end
  end

  // Next state.
  always_comb begin
    phase_d  = c_phase;
    hdr_d    = c_hdr;
    id_d     = c_id;
    chunk_d  = c_chunk;
    form_d   = form_dec;
    inside_d = c_inside;
    rec_d    = c_rec;
    vcnt_d   = c_vcnt;
    fcnt_d   = c_fcnt;

    case (c_phase)
      PH_ID: begin
        id_d  = {c_id[23:0], beat_i.data};
        hdr_d = c_hdr + 2'd1;
        if (c_hdr == HDR_LAST) begin
          phase_d = PH_SIZE;
        end
      end
      PH_SIZE: begin
        chunk_d = size_new;
        hdr_d   = c_hdr + 2'd1;
        if (c_hdr == HDR_LAST) begin
          rec_d = 4'd0;
          if (!c_inside && (c_id == ID_FORM)) begin
            if (size_new == 32'd0) begin
              phase_d = PH_ID;
            end else begin
              inside_d = 1'b1;
              form_d   = size_new;
              chunk_d  = 32'd0;
              phase_d  = PH_FORM_TYPE;
            end
          end else begin
            chunk_d = size_clamp;
            phase_d = (size_clamp != 32'd0) ? PH_BODY : PH_ID;
          end
        end
      end
      PH_FORM_TYPE: begin
        hdr_d = c_hdr + 2'd1;
        if (c_hdr == HDR_LAST) begin
          phase_d = PH_ID;
        end
      end
      PH_BODY: begin
        chunk_d = chunk_dec;
        if (is_data) begin
          rec_d = rec_inc;
          if (pnts_done) begin
            rec_d  = 4'd0;
            vcnt_d = (c_vcnt == COUNT_MAX) ? COUNT_MAX : c_vcnt + 24'd1;
          end else if (pols_done) begin
            rec_d  = 4'd0;
            fcnt_d = (c_fcnt == COUNT_MAX) ? COUNT_MAX : c_fcnt + 24'd1;
          end
        end
        if (chunk_dec == 32'd0) begin
          phase_d = PH_ID;
          rec_d   = 4'd0;
        end
      end
      default: begin
        phase_d = PH_ID;
      end
    endcase

    // The end of the enclosing FORM cuts off whatever was in progress.
    if (form_end) begin
      inside_d = 1'b0;
      form_d   = 32'd0;
      chunk_d  = 32'd0;
      phase_d  = PH_ID;
      hdr_d    = 2'd0;
      rec_d    = 4'd0;
    end
  end

  // Result of this byte.
  always_comb begin
    emit_o               = 1'b0;
    result_o.kind        = KIND_VERTEX;
    result_o.value_a     = words_d[0];
    result_o.value_b     = words_d[1];
    result_o.value_c     = words_d[2];
    result_o.number      = c_vcnt;
    result_o.count_error = 1'b0;
    if (body_data && pnts_done) begin
      emit_o = fire_i;
    end else if (body_data && pols_done) begin
      emit_o               = fire_i;
      result_o.kind        = KIND_FACE;
      result_o.value_a     = {16'd0, words_d[0][15:0]};
      result_o.value_b     = {16'd0, words_d[1][31:16]};
      result_o.value_c     = {16'd0, words_d[1][15:0]};
      result_o.number      = c_fcnt;
      result_o.count_error = (words_d[0][31:16] != FACE_VERTS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_ID;
      hdr_q    <= 2'd0;
      id_q     <= 32'd0;
      chunk_q  <= 32'd0;
      form_q   <= 32'd0;
      inside_q <= 1'b0;
      rec_q    <= 4'd0;
      vcnt_q   <= 24'd0;
      fcnt_q   <= 24'd0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      hdr_q    <= hdr_d;
      id_q     <= id_d;
      chunk_q  <= chunk_d;
      form_q   <= form_d;
      inside_q <= inside_d;
      rec_q    <= rec_d;
      vcnt_q   <= vcnt_d;
      fcnt_q   <= fcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      words_q <= words_d;
    end
  end

  a_body_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (chunk_q != 32'd0))
    else $error("body phase with no bytes left in the chunk");

  a_form_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inside_q |-> (form_q != 32'd0))
    else $error("inside a FORM with an exhausted byte count");

  a_top_form_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !inside_q |-> (form_q == 32'd0))
    else $error("stale FORM count at top level");

  a_form_type_nested: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FORM_TYPE) |-> inside_q)
    else $error("FORM type bytes outside a FORM");

  a_record_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_q < VERTEX_BYTES)
    else $error("record position past the longest record");

endmodule

// File: design/iffm_out_reg.sv
// Result register that holds one vertex or face beat until downstream takes it.
module iffm_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   emit_i,
  input  iffm_pkg::iffm_result_t result_i,
  output logic                   ready_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output iffm_pkg::iffm_result_t result_o
);
  import iffm_pkg::*;

  logic         valid_q;
  iffm_result_t result_q;

  // The register can take a new result when empty or when its beat leaves now.
  assign ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= emit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && emit_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  a_emit_only_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_stall_i) |-> !emit_i)
    else $error("result produced while the output register is blocked");

  a_new_beat_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ready_o && emit_i) |=> valid_q)
    else $error("produced result was not captured");

  a_taken_beat_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_stall_i && !emit_i) |=> !valid_q)
    else $error("delivered beat remained valid");

endmodule
